// File: sv/slp_pkg.sv
package slp_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] EXT_BYTE   = 8'h55;
  localparam logic [7:0] MAX_LEN    = 8'd170;
  localparam logic [7:0] LONG_CODE  = 8'h80;
  localparam logic [7:0] CLASS_MASK = 8'hC0;
  localparam logic [7:0] HIGH_TAG   = 8'h80;
  localparam logic [7:0] LOW_TAG    = 8'h40;
  localparam logic [7:0] SAT_MAX    = 8'hFF;
  localparam logic [7:0] RAW_LEN    = 8'd2;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] ADDR_MODE = 2'd0;

  typedef enum logic [2:0] {
    ST_SYNC1   = 3'd0,
    ST_SYNC2   = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_PAYLOAD = 3'd3,
    ST_CHECK   = 3'd4,
    ST_HIGH    = 3'd5,
    ST_LOW     = 3'd6
  } frame_state_t;

  typedef enum logic [1:0] {
    PH_CODE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_VALUE  = 2'd2
  } row_phase_t;

  typedef enum logic [2:0] {
    RK_VALUE     = 3'd0,
    RK_EMPTY_ROW = 3'd1,
    RK_GOOD      = 3'd2,
    RK_BAD_SUM   = 3'd3,
    RK_TOO_LONG  = 3'd4,
    RK_LEN_170   = 3'd5,
    RK_RAW_PAIR  = 3'd6
  } result_kind_t;

  typedef struct packed {
    logic [7:0]   high_byte;
    logic [7:0]   data_byte;
    logic [7:0]   byte_index;
    logic [7:0]   row_length;
    logic [7:0]   row_code;
    logic [7:0]   ext_level;
    result_kind_t kind;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: sv/slp_front.sv
module slp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mode,
  input  logic            restart,
  input  logic            byte_valid,
  input  logic [7:0]      byte_in,
  output logic            res_valid,
  output slp_pkg::result_t res
);
  import slp_pkg::*;

  frame_state_t fs_r, fs_nxt;
  row_phase_t   ph_r, ph_nxt;
  logic [7:0] plen_r, plen_nxt;
  logic [7:0] brx_r, brx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] ext_r, ext_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] rlen_r, rlen_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] pos_inc;
  logic       row_clr;

  frame_state_t start_st;
  assign start_st = mode ? ST_HIGH : ST_SYNC1;
  assign pos_inc  = pos_r + 8'd1;

  always_comb begin
    fs_nxt    = fs_r;
    ph_nxt    = ph_r;
    plen_nxt  = plen_r;
    brx_nxt   = brx_r;
    sum_nxt   = sum_r;
    prev_nxt  = byte_in;
    ext_nxt   = ext_r;
    code_nxt  = code_r;
    rlen_nxt  = rlen_r;
    pos_nxt   = pos_r;
    row_clr   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = RK_VALUE;

    case (fs_r)
      ST_SYNC1: begin
        if (byte_in == SYNC_BYTE) fs_nxt = ST_SYNC2;
      end
      ST_SYNC2: begin
        fs_nxt = (byte_in == SYNC_BYTE) ? ST_LENGTH : ST_SYNC1;
      end
      ST_LENGTH: begin
        plen_nxt = byte_in;
        if (byte_in > MAX_LEN) begin
          fs_nxt    = ST_SYNC1;
          res_valid = 1'b1;
          res.kind  = RK_TOO_LONG;
        end else if (byte_in == MAX_LEN) begin
          res_valid = 1'b1;
          res.kind  = RK_LEN_170;
        end else begin
          brx_nxt = '0;
          sum_nxt = '0;
          row_clr = 1'b1;
          fs_nxt  = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        sum_nxt = sum_r + byte_in;
        if (brx_r < plen_r) begin
          case (ph_r)
            PH_CODE: begin
              if (byte_in == EXT_BYTE) begin
                if (ext_r != SAT_MAX) ext_nxt = ext_r + 8'd1;
              end else begin
                code_nxt = byte_in;
                pos_nxt  = '0;
                if (byte_in >= LONG_CODE) begin
                  ph_nxt = PH_LENGTH;
                end else begin
                  rlen_nxt = 8'd1;
                  ph_nxt   = PH_VALUE;
                end
              end
            end
            PH_LENGTH: begin
              rlen_nxt = byte_in;
              pos_nxt  = '0;
              if (byte_in == 8'd0) begin
                res_valid     = 1'b1;
                res.kind      = RK_EMPTY_ROW;
                res.ext_level = ext_r;
                res.row_code  = code_r;
                row_clr       = 1'b1;
              end else begin
                ph_nxt = PH_VALUE;
              end
            end
            default: begin
              res_valid      = 1'b1;
              res.kind       = RK_VALUE;
              res.ext_level  = ext_r;
              res.row_code   = code_r;
              res.row_length = rlen_r;
              res.byte_index = pos_r;
              res.data_byte  = byte_in;
              pos_nxt        = pos_inc;
              if (pos_inc >= rlen_r) row_clr = 1'b1;
            end
          endcase
        end
        if (brx_r != SAT_MAX) brx_nxt = brx_r + 8'd1;
        if (brx_nxt >= plen_r) fs_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        fs_nxt    = ST_SYNC1;
        res_valid = 1'b1;
        res.kind  = (byte_in == ~sum_r) ? RK_GOOD : RK_BAD_SUM;
        row_clr   = 1'b1;
      end
      ST_HIGH: begin
        if ((byte_in & CLASS_MASK) == HIGH_TAG) fs_nxt = ST_LOW;
      end
      ST_LOW: begin
        if ((byte_in & CLASS_MASK) == LOW_TAG) begin
          res_valid      = 1'b1;
          res.kind       = RK_RAW_PAIR;
          res.row_code   = LONG_CODE;
          res.row_length = RAW_LEN;
          res.data_byte  = byte_in;
          res.high_byte  = prev_r;
        end
        fs_nxt = ST_HIGH;
      end
      default: begin
        fs_nxt = start_st;
      end
    endcase

    if (row_clr) begin
      ph_nxt   = PH_CODE;
      ext_nxt  = '0;
      code_nxt = '0;
      rlen_nxt = '0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      fs_r   <= rst_n ? start_st : ST_SYNC1;
      ph_r   <= PH_CODE;
      plen_r <= '0;
      brx_r  <= '0;
      sum_r  <= '0;
      prev_r <= '0;
      ext_r  <= '0;
      code_r <= '0;
      rlen_r <= '0;
      pos_r  <= '0;
    end else if (byte_valid) begin
      fs_r   <= fs_nxt;
      ph_r   <= ph_nxt;
      plen_r <= plen_nxt;
      brx_r  <= brx_nxt;
      sum_r  <= sum_nxt;
      prev_r <= prev_nxt;
      ext_r  <= ext_nxt;
      code_r <= code_nxt;
      rlen_r <= rlen_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// File: sv/slp_queue.sv
module slp_queue #(
  parameter int DEPTH = slp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slp_pkg::result_t    push_data,
  input  logic                pop,
  output slp_pkg::result_t    pop_data,
  output slp_pkg::q_status_t  status
);
  import slp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == FULL);
  assign status.empty = (cnt_r == '0);
  assign pop_data     = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= (wr_r == LAST) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + PW'(1);
    end
  end

endmodule

// File: sv/slp_back.sv
module slp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slp_pkg::q_status_t q_status,
  input  slp_pkg::result_t   q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,
  output logic [2:0]         out_tuser
);
  import slp_pkg::*;

  logic    vld_r;
  result_t res_r;

  // refill the output register when it is empty or being drained
  assign q_pop      = !q_status.empty && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {res_r.high_byte, res_r.data_byte, res_r.byte_index,
                       res_r.row_length, res_r.row_code, res_r.ext_level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_data;
  end

endmodule

// File: sv/sync_length_checksum_packet_parser.sv
// Channel  | Ports                          | Item
// ---------+--------------------------------+----------------------------------------
// input    | in_tvalid/in_tready/in_tdata   | one received byte
// output   | out_tvalid/out_tready/out_t*   | one result: kind on tuser, fields on tdata
// config   | cfg_psel..cfg_prdata (APB)     | parser_mode at address 0
//
// One byte is accepted per cycle while in_tready is high; a result it yields is
// written into the queue at the accepting edge and moves on into the output
// register once that is empty or draining (front logic -> queue -> output register).
// Reset is synchronous, active low; a write to parser_mode restarts the parser.
// A four-item queue sits between the byte parser and the output register, so
// in_tready drops only once the output has stalled long enough to fill it.
module sync_length_checksum_packet_parser #(
  parameter int QUEUE_DEPTH = slp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // ext_level, row_code, row_length, byte_index,
                                    // data_byte, high_byte (8 bits each, low first)
  output logic [2:0]  out_tuser,    // [2:0] result_kind
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import slp_pkg::*;

  logic       mode_r;
  logic       cfg_wr;
  logic       in_acc;
  logic       push;
  logic       pop;
  result_t    push_data;
  result_t    pop_data;
  q_status_t  q_stat;

  // config port: word address 0 holds the mode bit
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == ADDR_MODE[0]);
  assign cfg_prdata = (cfg_paddr[2] == ADDR_MODE[0]) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !q_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  logic res_valid;

  slp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (cfg_wr ? cfg_pwdata[0] : mode_r),
    .restart    (cfg_wr),
    .byte_valid (in_acc),
    .byte_in    (in_tdata),
    .res_valid  (res_valid),
    .res        (push_data)
  );

  assign push = in_acc && res_valid;

  slp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_stat)
  );

  slp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_stat),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // raw mode only ever produces raw pairs
  a_raw_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push && mode_r && !cfg_wr) |-> (push_data.kind == RK_RAW_PAIR))
    else $error("non-raw result in raw mode");

  // packet mode never produces raw pairs
  a_pkt_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !mode_r && !cfg_wr) |-> (push_data.kind != RK_RAW_PAIR))
    else $error("raw pair in packet mode");

  // queue never pushed while full, never popped while empty
  a_q_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("queue overflow or underflow");

  // a popped item shows on the output next cycle
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tuser == $past(pop_data.kind)))
    else $error("popped item not presented");

endmodule

// File: verif/slp_result_checker.sv
module slp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  input  logic        run_over,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import slp_pkg::*;

  // parser state as predicted
  logic         mode_q;
  frame_state_t fsm;
  row_phase_t   rphase;
  logic [7:0]   pay_len;
  logic [7:0]   got_cnt;
  logic [7:0]   sum_acc;
  logic [7:0]   last_byte;
  logic [7:0]   ext_cnt;
  logic [7:0]   code_q;
  logic [7:0]   rlen_q;
  logic [7:0]   rpos;
  result_t      results_due[$];
  bit           leftovers_checked;

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    leftovers_checked = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
  endtask

  task automatic clear_row();
    rphase = PH_CODE;
    ext_cnt = 8'd0;
    code_q = 8'd0;
    rlen_q = 8'd0;
    rpos = 8'd0;
  endtask

  task automatic restart_parser();
    fsm = mode_q ? ST_HIGH : ST_SYNC1;
    pay_len = 8'd0;
    got_cnt = 8'd0;
    sum_acc = 8'd0;
    last_byte = 8'd0;
    clear_row();
  endtask

  task automatic add_result(input result_kind_t k, input logic [7:0] ext, code, len, idx,
                            data, hi);
    result_t r;
    r.kind = k;
    r.ext_level = ext;
    r.row_code = code;
    r.row_length = len;
    r.byte_index = idx;
    r.data_byte = data;
    r.high_byte = hi;
    results_due.push_back(r);
  endtask

  // one payload byte into the row splitter
  task automatic row_byte(input logic [7:0] b);
    case (rphase)
      PH_CODE: begin
        if (b == EXT_BYTE) begin
          if (ext_cnt != SAT_MAX) ext_cnt = ext_cnt + 8'd1;
        end else begin
          code_q = b;
          rpos = 8'd0;
          if (b >= LONG_CODE) begin
            rphase = PH_LENGTH;
          end else begin
            rlen_q = 8'd1;
            rphase = PH_VALUE;
          end
        end
      end
      PH_LENGTH: begin
        rlen_q = b;
        rpos = 8'd0;
        if (b == 8'd0) begin
          add_result(RK_EMPTY_ROW, ext_cnt, code_q, 8'd0, 8'd0, 8'd0, 8'd0);
          clear_row();
        end else begin
          rphase = PH_VALUE;
        end
      end
      default: begin
        add_result(RK_VALUE, ext_cnt, code_q, rlen_q, rpos, b, 8'd0);
        rpos = rpos + 8'd1;
        if (rpos >= rlen_q) clear_row();
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (fsm)
      ST_SYNC1: if (b == SYNC_BYTE) fsm = ST_SYNC2;
      ST_SYNC2: fsm = (b == SYNC_BYTE) ? ST_LENGTH : ST_SYNC1;
      ST_LENGTH: begin
        pay_len = b;
        if (b > MAX_LEN) begin
          fsm = ST_SYNC1;
          add_result(RK_TOO_LONG, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        end else if (b == MAX_LEN) begin
          add_result(RK_LEN_170, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        end else begin
          got_cnt = 8'd0;
          sum_acc = 8'd0;
          clear_row();
          fsm = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        sum_acc = sum_acc + b;
        if (got_cnt < pay_len) row_byte(b);
        if (got_cnt != SAT_MAX) got_cnt = got_cnt + 8'd1;
        if (got_cnt >= pay_len) fsm = ST_CHECK;
      end
      ST_CHECK: begin
        fsm = ST_SYNC1;
        if (b == ~sum_acc)
          add_result(RK_GOOD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        else
          add_result(RK_BAD_SUM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        clear_row();
      end
      ST_HIGH: if ((b & CLASS_MASK) == HIGH_TAG) fsm = ST_LOW;
      ST_LOW: begin
        if ((b & CLASS_MASK) == LOW_TAG)
          add_result(RK_RAW_PAIR, 8'd0, LONG_CODE, RAW_LEN, 8'd0, b, last_byte);
        fsm = ST_HIGH;
      end
      default: fsm = mode_q ? ST_HIGH : ST_SYNC1;
    endcase
    last_byte = b;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      mode_q = 1'b0;
      restart_parser();
      results_due.delete();
    end else begin
      // drain side first: a result leaving now belongs to an older item
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d (kind %0d) arrived with none pending",
                                  results_seen, out_tuser));
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", {5'd0, out_tuser}, {5'd0, want.kind});
          check_field("ext_level", out_tdata[7:0], want.ext_level);
          check_field("row_code", out_tdata[15:8], want.row_code);
          check_field("row_length", out_tdata[23:16], want.row_length);
          check_field("byte_index", out_tdata[31:24], want.byte_index);
          check_field("data_byte", out_tdata[39:32], want.data_byte);
          check_field("high_byte", out_tdata[47:40], want.high_byte);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == 3'(ADDR_MODE)) begin
        if (cfg_pwrite) begin
          mode_q = cfg_pwdata[0];
          restart_parser();
        end else if (cfg_prdata !== {31'd0, mode_q}) begin
          flag_mismatch($sformatf("parser_mode read %0h want %0h", cfg_prdata, mode_q));
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (run_over && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (results_due.size() != 0)
          flag_mismatch($sformatf("%0d results never delivered", results_due.size()));
      end
    end
    pending <= results_due.size();
  end

endmodule

// File: verif/sync_length_checksum_packet_parser_test.sv
module sync_length_checksum_packet_parser_test;
  import slp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // clock, reset and all block inputs start at known values
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [47:0] out_tdata;   // ext_level, row_code, row_length, byte_index, data_byte, high_byte
  logic [2:0]  out_tuser;   // [2:0] result_kind
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        run_over = 1'b0;

  int fail_count;
  int pending;
  int results_seen;
  int bytes_sent = 0;
  int frames_sent = 0;
  int mode_writes = 0;

  // when set, the sender streams back to back with no gaps
  bit steady_send = 1'b0;
  int unsigned ready_hold = 0;

  sync_length_checksum_packet_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicts every result from the accepted bytes and compares in order
  slp_result_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .run_over     (run_over),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop. Worst case is roughly 1900 items, each with the longest send
  // gap and the longest output stall; this is several times that.
  initial begin
    #8000000;
    $display("timeout: run did not complete");
    $display("CHECK FAILED");
    $finish;
  end

  // Output backpressure: mostly ready, short stalls common, a few long ones,
  // and now and then a long stretch with no stall at all.
  always @(posedge clk) begin
    int unsigned r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 12);
      end else if (r < 62) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(40, 120);
      end else if (r < 88) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (r < 97) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(3, 9);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(20, 39);
      end
    end
  end

  // idle cycles before the next item: mostly none, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one byte and hold it until the handshake. Returns at the accepting
  // edge with tvalid still high, so back-to-back items never drop valid.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady_send ? 0 : gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // stop sending and wait for every predicted result to come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a trailing byte with no result may still be in the pipe
    repeat (4) @(posedge clk);
  endtask

  // APB write of parser_mode, then read it back (checker compares prdata).
  // Upper data bits are random; the register only keeps bit 0.
  task automatic write_mode(input logic m);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(ADDR_MODE);
    cfg_pwdata  <= ($urandom() & 32'hFFFF_FFFE) | {31'd0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);  // write lands at this edge
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    mode_writes++;
  endtask

  // Full frame: two syncs, optional length-170 byte (parser keeps waiting
  // for a length), the length, the body and a right or wrong checksum.
  task automatic send_frame(input logic [7:0] len, input byte_q_t body, input bit sum_ok,
                            input bit lead_170);
    logic [7:0] sum;
    sum = 8'd0;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    if (lead_170) send_byte(MAX_LEN);
    send_byte(len);
    foreach (body[i]) begin
      send_byte(body[i]);
      sum = sum + body[i];
    end
    send_byte(sum_ok ? ~sum : ~sum ^ 8'h01);
    frames_sent++;
  endtask

  // Payload made of well-formed rows with random content, cut at len so
  // the last row is often left open. A zero length still takes one byte.
  function automatic byte_q_t make_payload(input int unsigned len);
    byte_q_t body;
    int unsigned ext_n;
    int unsigned vlen;
    if (len == 0) begin
      body.push_back(8'($urandom_range(0, 255)));
      return body;
    end
    while (body.size() < len) begin
      ext_n = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 4);
      repeat (ext_n) body.push_back(EXT_BYTE);
      if ($urandom_range(0, 1) == 0) begin
        // short code: one value byte implied
        body.push_back(8'($urandom_range(0, 127)));
        vlen = 1;
      end else begin
        body.push_back(LONG_CODE | 8'($urandom_range(0, 127)));
        vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        body.push_back(8'(vlen));
      end
      repeat (vlen) body.push_back(8'($urandom_range(0, 255)));
    end
    while (body.size() > len) void'(body.pop_back());
    return body;
  endfunction

  // packet mode: mostly good frames, plus noise, broken syncs and bad lengths
  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    steady_send = ($urandom_range(0, 9) < 3);
    if (pick < 7) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 11) begin
      // lone sync, then anything
      send_byte(SYNC_BYTE);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 15) begin
      // oversize length drops the frame
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);
      send_byte(8'($urandom_range(171, 255)));
    end else begin
      len = (pick < 19) ? $urandom_range(100, 169) : $urandom_range(0, 24);
      send_frame(8'(len), make_payload(len), $urandom_range(0, 9) != 0, pick < 23);
    end
  endtask

  // raw mode: mostly high/low pairs, some orphaned highs and noise
  task automatic random_raw();
    int unsigned pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    steady_send = ($urandom_range(0, 9) < 3);
    if (pick < 75) begin
      send_byte(HIGH_TAG | 8'($urandom_range(0, 63)));
      send_byte(LOW_TAG | 8'($urandom_range(0, 63)));
    end else if (pick < 87) begin
      send_byte(HIGH_TAG | 8'($urandom_range(0, 63)));
      b = 8'($urandom_range(0, 255));
      if ((b & CLASS_MASK) == LOW_TAG) b = b ^ LOW_TAG;
      send_byte(b);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    byte_q_t body;
    bit mode_plan[6];
    int phase_end;
    bit paused;
    mode_plan = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    paused = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, packet mode from reset ---
    // length 170 keeps waiting for a length; the next one is oversize
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(MAX_LEN);
    send_byte(8'hFF);
    // zero length still eats one byte, no row, good checksum
    body = '{8'h3C};
    send_frame(8'd0, body, 1'b1, 1'b0);
    // two extensions + empty long row, then a short row cut off; bad sum
    body = '{EXT_BYTE, EXT_BYTE, 8'h81, 8'h00, 8'h02};
    send_frame(8'd5, body, 1'b0, 1'b0);
    // long code with two value bytes at both extremes
    body = '{8'h80, 8'h02, 8'hFF, 8'h00};
    send_frame(8'd4, body, 1'b1, 1'b0);
    drain_results();

    // --- directed, raw mode ---
    write_mode(1'b1);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hBF);
    send_byte(8'h40);
    // high with no low after it: dropped
    send_byte(8'h80);
    send_byte(8'hC0);

    // --- random phases, alternating and repeating modes ---
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_mode(mode_plan[ph]);
      if (ph == 0) begin
        // deepest extension chain a legal payload allows, then one value
        body.delete();
        repeat (167) body.push_back(EXT_BYTE);
        body.push_back(8'h01);
        body.push_back(8'hFF);
        send_frame(8'd169, body, 1'b1, 1'b0);
      end
      phase_end = bytes_sent + 270;
      while (bytes_sent < phase_end) begin
        if (mode_plan[ph]) random_raw();
        else random_frame();
        // sender holds off mid-phase until the output side has caught up
        if (ph == 2 && !paused && bytes_sent >= phase_end - 135) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    run_over <= 1'b1;
    repeat (3) @(posedge clk);

    $display("run covered %0d bytes (%0d built frames) over %0d parser_mode writes",
             bytes_sent, frames_sent, mode_writes);
    $display("%0d results compared in packet and raw pairing modes", results_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/slp_pkg.sv
sv/slp_front.sv
sv/slp_queue.sv
sv/slp_back.sv
sv/sync_length_checksum_packet_parser.sv
verif/slp_result_checker.sv
verif/sync_length_checksum_packet_parser_test.sv
